### hw/rtl/pit_pkg.sv
// Shared types, codes and defaults of the process-ID table.
package pit_pkg;

  localparam int SLOTS_DEF    = 128;
  localparam int ID_LIMIT_DEF = 32767;
  localparam int ID_FIRST_DEF = 2;
  localparam int BOOT_ID_DEF  = 1;

  localparam int PID_W  = 15;
  localparam int CID_W  = 16;
  localparam int STAT_W = 32;
  localparam int SIG_W  = 5;

  localparam logic [STAT_W-1:0] STATUS_FRESH = 32'h0000_baad;

  typedef enum logic [2:0] {
    ACT_ALLOC   = 3'd0,
    ACT_UNALLOC = 3'd1,
    ACT_DETACH  = 3'd2,
    ACT_EXIT    = 3'd3,
    ACT_JOIN    = 3'd4,
    ACT_SETSIG  = 3'd5,
    ACT_GETSIG  = 3'd6,
    ACT_BAD     = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    RC_OK       = 3'd0,
    RC_FULL     = 3'd1,
    RC_NOPROC   = 3'd2,
    RC_INVAL    = 3'd3,
    RC_DEADLK   = 3'd4,
    RC_NOTCHILD = 3'd5,
    RC_UNIMP    = 3'd6,
    RC_NOTEXIT  = 3'd7
  } rc_t;

  localparam logic [SIG_W-1:0] SG_STOP = 5'd17;
  localparam logic [SIG_W-1:0] SG_CONT = 5'd19;

  typedef struct packed {
    logic              used;
    logic [CID_W-1:0]  id;
    logic [PID_W-1:0]  parent;
    logic              exited;
    logic [STAT_W-1:0] status;
    logic [SIG_W-1:0]  signal;
    logic              joinable;
  } entry_t;

  typedef struct packed {
    logic             start;
    logic [CID_W-1:0] id;
  } mod_req_t;

  function automatic logic sig_supported(input logic [7:0] s);
    return (s == 8'd1) || (s == 8'd2) || (s == 8'd9) || (s == 8'd15) ||
           (s == 8'd17) || (s == 8'd19) || (s == 8'd28) || (s == 8'd29);
  endfunction

endpackage

### hw/rtl/pit_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
module pit_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hw/rtl/pit_mod.sv
// Id-to-slot reduction (id mod SLOTS) by reciprocal multiplication, pipelined through id, quotient and slot registers.
module pit_mod
  import pit_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mod_req_t                 req,
  output logic                     done,
  output logic [$clog2(SLOTS)-1:0] slot
);
  localparam int SW = $clog2(SLOTS);
  localparam logic [31:0]      RECIP   = 32'((64'd1 << 32) / SLOTS);
  localparam logic [CID_W-1:0] SLOTS_C = CID_W'(SLOTS);

  logic [CID_W-1:0]  id_r, id_nxt, q_r, q_nxt;
  logic [SW-1:0]     slot_r, slot_nxt;
  logic              s1_r, s2_r, done_r;
  logic [CID_W+31:0] prod;
  logic [CID_W-1:0]  rem;

  // quotient estimate is exact or one low, so one conditional subtract fixes the remainder
  always_comb begin
    id_nxt   = req.start ? req.id : id_r;
    prod     = {32'd0, id_r} * {{CID_W{1'b0}}, RECIP};
    q_nxt    = s1_r ? prod[CID_W+31:32] : q_r;
    rem      = id_r - q_r * SLOTS_C;
    slot_nxt = slot_r;
    if (s2_r) begin
      slot_nxt = (rem >= SLOTS_C) ? SW'(rem - SLOTS_C) : SW'(rem);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r   <= 1'b0;
      s2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      s1_r   <= req.start;
      s2_r   <= s1_r;
      done_r <= s2_r;
    end
    id_r   <= id_nxt;
    q_r    <= q_nxt;
    slot_r <= slot_nxt;
  end

  assign done = done_r;
  assign slot = slot_r;
endmodule

### hw/rtl/process_id_table.sv
// Top level of the direct-mapped process-ID table.
// One word in, one word out. The entries live in one RAM of SLOTS rows with registered read.
// After reset a clearing pass writes every row with in_ready low. Lookup actions reduce
// the id to a slot (reciprocal multiply) and then read the RAM row and check it or write
// it back. Allocate reads and checks one candidate at a time, up to 2*SLOTS+5 candidates.
// Exit sweeps all SLOTS rows at one row per cycle, then reads and updates the caller's row.
// A new word is accepted while the previous result waits on the output register.
module process_id_table
  import pit_pkg::*;
#(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int ID_LIMIT = ID_LIMIT_DEF,
  parameter int ID_FIRST = ID_FIRST_DEF,
  parameter int BOOT_ID  = BOOT_ID_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               in_action,
  input  logic [PID_W-1:0]         in_caller_pid,
  input  logic [PID_W-1:0]         in_target_pid,
  input  logic signed [STAT_W-1:0] in_exit_status,
  input  logic                     in_detach_children,
  input  logic                     in_no_hang,
  input  logic signed [7:0]        in_signal_number,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [2:0]               out_result_code,
  output logic [PID_W-1:0]         out_result_pid,
  output logic signed [STAT_W-1:0] out_status_value,
  output logic [SIG_W-1:0]         out_signal_value
);
  localparam int SW  = $clog2(SLOTS);
  localparam int UCW = $clog2(SLOTS + 1);
  localparam int TW  = $clog2(2 * SLOTS + 6);
  localparam int EW  = $bits(entry_t);
  localparam logic [SW-1:0]    BOOT_SLOT  = SW'(BOOT_ID % SLOTS);
  localparam logic [SW-1:0]    FIRST_SLOT = SW'(ID_FIRST % SLOTS);
  localparam logic [SW-1:0]    LAST_SLOT  = SW'(SLOTS - 1);
  localparam logic [CID_W-1:0] LIMIT_C    = CID_W'(ID_LIMIT);
  localparam logic [CID_W-1:0] FIRST_C    = CID_W'(ID_FIRST);
  localparam logic [CID_W-1:0] BOOT_C     = CID_W'(BOOT_ID);
  localparam logic [TW-1:0]    TRY_LIMIT  = TW'(2 * SLOTS + 5);
  localparam logic [UCW-1:0]   SLOTS_U    = UCW'(SLOTS);
  localparam logic [SW:0]      SLOTS_X    = (SW + 1)'(SLOTS);

  typedef enum logic [10:0] {
    ST_CLR   = 11'b000_0000_0001,
    ST_IDLE  = 11'b000_0000_0010,
    ST_MOD   = 11'b000_0000_0100,
    ST_LRD   = 11'b000_0000_1000,
    ST_LCHK  = 11'b000_0001_0000,
    ST_ARD   = 11'b000_0010_0000,
    ST_ACHK  = 11'b000_0100_0000,
    ST_XSCAN = 11'b000_1000_0000,
    ST_XFRD  = 11'b001_0000_0000,
    ST_XFIN  = 11'b010_0000_0000,
    ST_DONE  = 11'b100_0000_0000
  } state_t;

  state_t             state_r, state_nxt;
  action_t            act_r, act_nxt;
  logic [PID_W-1:0]   caller_r, caller_nxt, target_r, target_nxt;
  logic [STAT_W-1:0]  estat_r, estat_nxt;
  logic               det_r, det_nxt, nh_r, nh_nxt;
  logic [SIG_W-1:0]   sig_r, sig_nxt;
  rc_t                rc_r, rc_nxt;
  logic [PID_W-1:0]   rpid_r, rpid_nxt;
  logic [STAT_W-1:0]  rstat_r, rstat_nxt;
  logic [SIG_W-1:0]   rsig_r, rsig_nxt;
  logic [CID_W-1:0]   ncand_r, ncand_nxt, cand_r, cand_nxt;
  logic [SW-1:0]      ncslot_r, ncslot_nxt, cslot_r, cslot_nxt, clr_r, clr_nxt;
  logic [TW-1:0]      tries_r, tries_nxt;
  logic [UCW-1:0]     ucnt_r, ucnt_nxt;
  logic [SW:0]        xi_r, xi_nxt;
  logic               wbv_r, wbv_nxt;
  logic [SW-1:0]      wbi_r, wbi_nxt;
  logic               ov_r, ov_nxt;
  logic [2:0]         orc_r, orc_nxt;
  logic [PID_W-1:0]   opid_r, opid_nxt;
  logic [STAT_W-1:0]  ostat_r, ostat_nxt;
  logic [SIG_W-1:0]   osig_r, osig_nxt;

  logic               ram_we;
  logic [SW-1:0]      ram_waddr, ram_raddr;
  entry_t             ram_wdata, rd;
  logic [EW-1:0]      ram_rdata;
  mod_req_t           mreq;
  logic               mdone;
  logic [SW-1:0]      mslot;

  logic               acc;
  logic [CID_W-1:0]   key, cand_adv;
  logic [SW-1:0]      cslot_adv;
  logic               present, cand_wrap;
  entry_t             boot_e, tmp_e;

  pit_ram #(.W(EW), .D(SLOTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pit_mod #(.SLOTS(SLOTS)) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .done  (mdone),
    .slot  (mslot)
  );

  assign rd        = entry_t'(ram_rdata);
  assign acc       = in_valid && in_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign key       = (act_r == ACT_EXIT) ? {1'b0, caller_r} : {1'b0, target_r};
  assign present   = rd.used && (rd.id == key);
  assign cand_wrap = (cand_r >= LIMIT_C);
  assign cand_adv  = cand_wrap ? FIRST_C : cand_r + 1'b1;
  assign cslot_adv = cand_wrap ? FIRST_SLOT : ((cslot_r == LAST_SLOT) ? '0 : cslot_r + 1'b1);

  always_comb begin
    boot_e          = '0;
    boot_e.used     = 1'b1;
    boot_e.id       = BOOT_C;
    boot_e.status   = STATUS_FRESH;
    boot_e.joinable = 1'b1;
  end

  always_comb begin
    state_nxt  = state_r;
    act_nxt    = act_r;
    caller_nxt = caller_r;
    target_nxt = target_r;
    estat_nxt  = estat_r;
    det_nxt    = det_r;
    nh_nxt     = nh_r;
    sig_nxt    = sig_r;
    rc_nxt     = rc_r;
    rpid_nxt   = rpid_r;
    rstat_nxt  = rstat_r;
    rsig_nxt   = rsig_r;
    ncand_nxt  = ncand_r;
    ncslot_nxt = ncslot_r;
    cand_nxt   = cand_r;
    cslot_nxt  = cslot_r;
    tries_nxt  = tries_r;
    ucnt_nxt   = ucnt_r;
    clr_nxt    = clr_r;
    xi_nxt     = xi_r;
    wbv_nxt    = wbv_r;
    wbi_nxt    = wbi_r;
    ov_nxt     = ov_r;
    orc_nxt    = orc_r;
    opid_nxt   = opid_r;
    ostat_nxt  = ostat_r;
    osig_nxt   = osig_r;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_raddr  = '0;
    mreq       = '0;
    tmp_e      = rd;

    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = (clr_r == BOOT_SLOT) ? boot_e : '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == LAST_SLOT) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (acc) begin
          act_nxt    = action_t'(in_action);
          caller_nxt = in_caller_pid;
          target_nxt = in_target_pid;
          estat_nxt  = in_exit_status;
          det_nxt    = in_detach_children;
          nh_nxt     = in_no_hang;
          sig_nxt    = in_signal_number[SIG_W-1:0];
          rc_nxt     = RC_OK;
          rpid_nxt   = '0;
          rstat_nxt  = '0;
          rsig_nxt   = '0;
          mreq.id    = (action_t'(in_action) == ACT_EXIT) ? {1'b0, in_caller_pid}
                                                          : {1'b0, in_target_pid};
          priority if (action_t'(in_action) == ACT_BAD) begin
            rc_nxt    = RC_INVAL;
            state_nxt = ST_DONE;
          end else if (action_t'(in_action) == ACT_ALLOC) begin
            if (ucnt_r >= SLOTS_U) begin
              rc_nxt    = RC_FULL;
              state_nxt = ST_DONE;
            end else begin
              cand_nxt  = ncand_r;
              cslot_nxt = ncslot_r;
              tries_nxt = '0;
              state_nxt = ST_ARD;
            end
          end else if (action_t'(in_action) == ACT_UNALLOC &&
                       ({1'b0, in_target_pid} < FIRST_C ||
                        {1'b0, in_target_pid} > LIMIT_C)) begin
            rc_nxt    = RC_INVAL;
            state_nxt = ST_DONE;
          end else if (action_t'(in_action) == ACT_SETSIG && in_signal_number[7]) begin
            rc_nxt    = RC_INVAL;
            state_nxt = ST_DONE;
          end else if (action_t'(in_action) == ACT_SETSIG && in_signal_number == 8'sd0) begin
            state_nxt = ST_DONE;
          end else if (action_t'(in_action) == ACT_SETSIG &&
                       !sig_supported(in_signal_number)) begin
            rc_nxt    = RC_UNIMP;
            state_nxt = ST_DONE;
          end else begin
            mreq.start = 1'b1;
            state_nxt  = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        if (mdone) begin
          state_nxt = ST_LRD;
        end
      end
      ST_LRD: begin
        ram_raddr = mslot;
        state_nxt = ST_LCHK;
      end
      ST_LCHK: begin
        ram_waddr = mslot;
        state_nxt = ST_DONE;
        if (!present) begin
          rc_nxt = RC_NOPROC;
        end else begin
          unique case (act_r)
            ACT_UNALLOC: begin
              if (rd.exited || rd.parent != caller_r) begin
                rc_nxt = RC_INVAL;
              end else begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                if (ucnt_r != '0) ucnt_nxt = ucnt_r - 1'b1;
              end
            end
            ACT_DETACH: begin
              if (rd.parent == '0 || rd.parent != caller_r ||
                  key == '0 || key == BOOT_C) begin
                rc_nxt = RC_INVAL;
              end else begin
                tmp_e.joinable = 1'b0;
                tmp_e.parent   = '0;
                ram_we         = 1'b1;
                ram_wdata      = tmp_e;
              end
            end
            ACT_EXIT: begin
              xi_nxt    = '0;
              wbv_nxt   = 1'b0;
              state_nxt = ST_XSCAN;
            end
            ACT_JOIN: begin
              priority if (key == '0 || key == BOOT_C) rc_nxt = RC_INVAL;
              else if (target_r == caller_r) rc_nxt = RC_DEADLK;
              else if (rd.parent != caller_r) rc_nxt = RC_NOTCHILD;
              else if (!rd.joinable) rc_nxt = RC_INVAL;
              else if (!rd.exited) rc_nxt = nh_r ? RC_OK : RC_NOTEXIT;
              else begin
                rpid_nxt  = target_r;
                rstat_nxt = rd.status;
              end
            end
            ACT_SETSIG: begin
              if (sig_r != SG_CONT || rd.signal == SG_STOP) begin
                tmp_e.signal = sig_r;
                ram_we       = 1'b1;
                ram_wdata    = tmp_e;
              end
            end
            ACT_GETSIG: rsig_nxt = rd.signal;
            default: rc_nxt = RC_INVAL;
          endcase
        end
      end
      ST_ARD: begin
        ram_raddr = cslot_r;
        tries_nxt = tries_r + 1'b1;
        state_nxt = ST_ACHK;
      end
      ST_ACHK: begin
        if (!rd.used) begin
          tmp_e          = '0;
          tmp_e.used     = 1'b1;
          tmp_e.id       = cand_r;
          tmp_e.parent   = caller_r;
          tmp_e.status   = STATUS_FRESH;
          tmp_e.joinable = 1'b1;
          ram_we         = 1'b1;
          ram_waddr      = cslot_r;
          ram_wdata      = tmp_e;
          ucnt_nxt       = ucnt_r + 1'b1;
          ncand_nxt      = cand_adv;
          ncslot_nxt     = cslot_adv;
          rpid_nxt       = cand_r[PID_W-1:0];
          state_nxt      = ST_DONE;
        end else if (tries_r == TRY_LIMIT) begin
          rc_nxt    = RC_FULL;
          state_nxt = ST_DONE;
        end else begin
          cand_nxt  = cand_adv;
          cslot_nxt = cslot_adv;
          state_nxt = ST_ARD;
        end
      end
      ST_XSCAN: begin
        if (xi_r < SLOTS_X) begin
          ram_raddr = xi_r[SW-1:0];
          wbv_nxt   = 1'b1;
          wbi_nxt   = xi_r[SW-1:0];
          xi_nxt    = xi_r + 1'b1;
        end else begin
          wbv_nxt = 1'b0;
        end
        if (wbv_r && rd.used && rd.parent == caller_r) begin
          tmp_e.parent = '0;
          if (det_r) tmp_e.joinable = 1'b0;
          ram_we    = 1'b1;
          ram_waddr = wbi_r;
          ram_wdata = tmp_e;
        end
        if (xi_r == SLOTS_X && !wbv_r) begin
          state_nxt = ST_XFRD;
        end
      end
      ST_XFRD: begin
        ram_raddr = mslot;
        state_nxt = ST_XFIN;
      end
      ST_XFIN: begin
        tmp_e.status = estat_r;
        tmp_e.exited = 1'b1;
        ram_we       = 1'b1;
        ram_waddr    = mslot;
        if (rd.parent == '0) begin
          ram_wdata = '0;
          if (ucnt_r != '0) ucnt_nxt = ucnt_r - 1'b1;
        end else begin
          ram_wdata = tmp_e;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          orc_nxt   = rc_r;
          opid_nxt  = rpid_r;
          ostat_nxt = rstat_r;
          osig_nxt  = rsig_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLR;
      clr_r    <= '0;
      ucnt_r   <= UCW'(1);
      ncand_r  <= FIRST_C;
      ncslot_r <= FIRST_SLOT;
      ov_r     <= 1'b0;
      wbv_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      ucnt_r   <= ucnt_nxt;
      ncand_r  <= ncand_nxt;
      ncslot_r <= ncslot_nxt;
      ov_r     <= ov_nxt;
      wbv_r    <= wbv_nxt;
    end
    act_r    <= act_nxt;
    caller_r <= caller_nxt;
    target_r <= target_nxt;
    estat_r  <= estat_nxt;
    det_r    <= det_nxt;
    nh_r     <= nh_nxt;
    sig_r    <= sig_nxt;
    rc_r     <= rc_nxt;
    rpid_r   <= rpid_nxt;
    rstat_r  <= rstat_nxt;
    rsig_r   <= rsig_nxt;
    cand_r   <= cand_nxt;
    cslot_r  <= cslot_nxt;
    tries_r  <= tries_nxt;
    xi_r     <= xi_nxt;
    wbi_r    <= wbi_nxt;
    orc_r    <= orc_nxt;
    opid_r   <= opid_nxt;
    ostat_r  <= ostat_nxt;
    osig_r   <= osig_nxt;
  end

  assign out_valid        = ov_r;
  assign out_result_code  = orc_r;
  assign out_result_pid   = opid_r;
  assign out_status_value = ostat_r;
  assign out_signal_value = osig_r;

  a_ucnt_bound: assert property (@(posedge clk) disable iff (!rst_n) ucnt_r <= SLOTS_U)
    else $error("used count above table size");
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_DONE) |-> !ram_we)
    else $error("table write outside an action");
  a_scan_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_XSCAN && ram_we && xi_r < SLOTS_X) |-> (ram_waddr != ram_raddr))
    else $error("exit sweep reads the row being written");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word taken while one is in work");
endmodule

### tb/pit_checker.sv
// Checker for the process-ID table: watches both channels, predicts each result and compares.
module pit_checker
  import pit_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [2:0]               in_action,
  input  logic [PID_W-1:0]         in_caller_pid,
  input  logic [PID_W-1:0]         in_target_pid,
  input  logic signed [STAT_W-1:0] in_exit_status,
  input  logic                     in_detach_children,
  input  logic                     in_no_hang,
  input  logic signed [7:0]        in_signal_number,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [2:0]               out_result_code,
  input  logic [PID_W-1:0]         out_result_pid,
  input  logic signed [STAT_W-1:0] out_status_value,
  input  logic [SIG_W-1:0]         out_signal_value,
  output int                       errors,
  output int                       pending
);

  localparam int NSLOT = SLOTS_DEF;
  localparam logic [STAT_W-1:0] STATUS_DROPPED = 32'h0000_dead;

  typedef struct {
    rc_t               code;
    logic [PID_W-1:0]  pid;
    logic [STAT_W-1:0] stat;
    logic [SIG_W-1:0]  sig;
  } reply_t;

  reply_t reply_q[$];

  bit                used_a  [NSLOT];
  logic [PID_W-1:0]  id_a    [NSLOT];
  logic [PID_W-1:0]  par_a   [NSLOT];
  bit                exit_a  [NSLOT];
  logic [STAT_W-1:0] stat_a  [NSLOT];
  logic [SIG_W-1:0]  sig_a   [NSLOT];
  bit                join_a  [NSLOT];
  int                next_id;
  int                live;

  function automatic void fill(int s, int id, int par);
    used_a[s] = 1; id_a[s] = PID_W'(id); par_a[s] = PID_W'(par); exit_a[s] = 0;
    stat_a[s] = STATUS_FRESH; sig_a[s] = 0; join_a[s] = 1; live++;
  endfunction

  function automatic void drop(int s);
    used_a[s] = 0; id_a[s] = 0; par_a[s] = 0; exit_a[s] = 0;
    stat_a[s] = 0; sig_a[s] = 0; join_a[s] = 0;
    if (live > 0) live--;
  endfunction

  function automatic void clear_table();
    for (int i = 0; i < NSLOT; i++) begin
      used_a[i] = 0; id_a[i] = 0; par_a[i] = 0; exit_a[i] = 0;
      stat_a[i] = 0; sig_a[i] = 0; join_a[i] = 0;
    end
    live = 0;
    fill(BOOT_ID_DEF % NSLOT, BOOT_ID_DEF, 0);
    next_id = ID_FIRST_DEF;
  endfunction

  function automatic int bump(int id);
    return (id + 1 > ID_LIMIT_DEF) ? ID_FIRST_DEF : id + 1;
  endfunction

  function automatic int lookup(int id);
    int s;
    s = id % NSLOT;
    return (used_a[s] && id_a[s] == id) ? s : -1;
  endfunction

  function automatic reply_t apply_word(logic [2:0] act, int caller, int target,
                                        logic [STAT_W-1:0] st, bit det, bit nh,
                                        logic signed [7:0] sn);
    reply_t r;
    int s, cand;
    bit found;
    r.code = RC_OK; r.pid = 0; r.stat = 0; r.sig = 0;
    case (act)
      ACT_ALLOC: begin
        cand = next_id;
        found = 0;
        if (live >= NSLOT) r.code = RC_FULL;
        else begin
          for (int i = 0; i < 2 * NSLOT + 5; i++) begin
            if (!used_a[cand % NSLOT]) begin
              found = 1;
              break;
            end
            cand = bump(cand);
          end
          if (!found) r.code = RC_FULL;
          else begin
            fill(cand % NSLOT, cand, caller);
            next_id = bump(cand);
            r.pid = PID_W'(cand);
          end
        end
      end
      ACT_UNALLOC: begin
        s = lookup(target);
        if (target < ID_FIRST_DEF || target > ID_LIMIT_DEF) r.code = RC_INVAL;
        else if (s < 0) r.code = RC_NOPROC;
        else if (exit_a[s] || par_a[s] != caller) r.code = RC_INVAL;
        else begin
          stat_a[s] = STATUS_DROPPED;
          drop(s);
        end
      end
      ACT_DETACH: begin
        s = lookup(target);
        if (s < 0) r.code = RC_NOPROC;
        else if (par_a[s] == 0 || par_a[s] != caller) r.code = RC_INVAL;
        else if (target == 0 || target == BOOT_ID_DEF) r.code = RC_INVAL;
        else begin
          join_a[s] = 0;
          par_a[s] = 0;
        end
      end
      ACT_EXIT: begin
        s = lookup(caller);
        if (s < 0) r.code = RC_NOPROC;
        else begin
          for (int i = 0; i < NSLOT; i++)
            if (used_a[i] && par_a[i] == caller) begin
              par_a[i] = 0;
              if (det) join_a[i] = 0;
            end
          stat_a[s] = st;
          exit_a[s] = 1;
          if (par_a[s] == 0) drop(s);
        end
      end
      ACT_JOIN: begin
        s = lookup(target);
        if (s < 0) r.code = RC_NOPROC;
        else if (target == 0 || target == BOOT_ID_DEF) r.code = RC_INVAL;
        else if (target == caller) r.code = RC_DEADLK;
        else if (par_a[s] != caller) r.code = RC_NOTCHILD;
        else if (!join_a[s]) r.code = RC_INVAL;
        else if (!exit_a[s]) r.code = nh ? RC_OK : RC_NOTEXIT;
        else begin
          r.pid = PID_W'(target);
          r.stat = stat_a[s];
        end
      end
      ACT_SETSIG: begin
        s = lookup(target);
        if (sn < 0) r.code = RC_INVAL;
        else if (sn == 0) r.code = RC_OK;
        else if (!(sn == 1 || sn == 2 || sn == 9 || sn == 15 || sn == 17 || sn == 19 ||
                   sn == 28 || sn == 29)) r.code = RC_UNIMP;
        else if (s < 0) r.code = RC_NOPROC;
        else if (sn == 19) begin
          if (sig_a[s] == SG_STOP) sig_a[s] = SG_CONT;
        end else sig_a[s] = sn[SIG_W-1:0];
      end
      ACT_GETSIG: begin
        s = lookup(target);
        if (s < 0) r.code = RC_NOPROC;
        else r.sig = sig_a[s];
      end
      default: r.code = RC_INVAL;
    endcase
    return r;
  endfunction

  initial begin
    errors = 0;
    pending = 0;
    clear_table();
  end

  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      clear_table();
      reply_q.delete();
    end else begin
      if (in_valid && in_ready)
        reply_q.push_back(apply_word(in_action, in_caller_pid, in_target_pid, in_exit_status,
                                     in_detach_children, in_no_hang, in_signal_number));
      if (out_valid && out_ready) begin
        if (reply_q.size() == 0) begin
          $display("%0t: unexpected word code=%0d pid=%0d", $time, out_result_code,
                   out_result_pid);
          errors++;
        end else begin
          want = reply_q.pop_front();
          if (out_result_code !== want.code) begin
            $display("%0t: code exp %0d got %0d", $time, want.code, out_result_code);
            errors++;
          end
          if (out_result_pid !== want.pid) begin
            $display("%0t: pid exp %0d got %0d", $time, want.pid, out_result_pid);
            errors++;
          end
          if (out_status_value !== want.stat) begin
            $display("%0t: status exp %h got %h", $time, want.stat, out_status_value);
            errors++;
          end
          if (out_signal_value !== want.sig) begin
            $display("%0t: signal exp %0d got %0d", $time, want.sig, out_signal_value);
            errors++;
          end
        end
      end
    end
    pending = reply_q.size();
  end

endmodule

### tb/process_id_table_tb.sv
// Testbench top of the process-ID table: stimulus, receiver stalls, watchdog and verdict.
module process_id_table_tb;
  import pit_pkg::*;

  localparam int N_RAND   = 1750;
  localparam int WD_LIMIT = 6000;
  localparam int HOLD_LEN = 400;

  logic                     clk = 0;
  logic                     rst_n = 0;
  logic                     in_valid = 0;
  logic                     in_ready;
  logic [2:0]               in_action = ACT_ALLOC;
  logic [PID_W-1:0]         in_caller_pid = 0;
  logic [PID_W-1:0]         in_target_pid = 0;
  logic signed [STAT_W-1:0] in_exit_status = 0;
  logic                     in_detach_children = 0;
  logic                     in_no_hang = 0;
  logic signed [7:0]        in_signal_number = 0;
  logic                     out_valid;
  logic                     out_ready = 0;
  logic [2:0]               out_result_code;
  logic [PID_W-1:0]         out_result_pid;
  logic signed [STAT_W-1:0] out_status_value;
  logic [SIG_W-1:0]         out_signal_value;
  int                       errors;
  int                       pending;

  bit  calm = 0;
  bit  hold_req = 0;
  int  hold_cnt = 0;
  int  quiet = 0;
  int  allocs = 0;

  always #10 clk = ~clk;

  process_id_table u_top (.*);

  pit_checker u_chk (.*);

  always @(posedge clk) begin
    if (hold_req && hold_cnt == 0) begin
      hold_cnt <= HOLD_LEN;
      hold_req <= 0;
      out_ready <= 0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= (hold_cnt == 1);
    end else
      out_ready <= calm || ($urandom_range(99) >= 36);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WD_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_word(logic [2:0] act, int caller, int target, logic [31:0] st,
                           bit det, bit nh, logic [7:0] sn);
    while (!calm && $urandom_range(99) < 36) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_action <= act;
    in_caller_pid <= PID_W'(caller);
    in_target_pid <= PID_W'(target);
    in_exit_status <= st;
    in_detach_children <= det;
    in_no_hang <= nh;
    in_signal_number <= sn;
    do @(posedge clk); while (!in_ready);
    if (act == ACT_ALLOC) allocs++;
  endtask

  function automatic logic [7:0] pick_sig();
    logic [7:0] good[8] = '{1, 2, 9, 15, 17, 19, 28, 29};
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'($urandom_range(128, 255));
      2: return 8'($urandom);
      default: return good[$urandom_range(7)];
    endcase
  endfunction

  task automatic random_word();
    int hi, w, caller, target;
    logic [2:0] act;
    hi = allocs + 3;
    if ($urandom_range(99) < 12) begin
      send_word(3'($urandom), 15'($urandom), 15'($urandom), $urandom, 1'($urandom),
                1'($urandom), 8'($urandom));
    end else begin
      w = $urandom_range(99);
      if (w < 30) act = ACT_ALLOC;
      else if (w < 38) act = ACT_UNALLOC;
      else if (w < 46) act = ACT_DETACH;
      else if (w < 60) act = ACT_EXIT;
      else if (w < 76) act = ACT_JOIN;
      else if (w < 88) act = ACT_SETSIG;
      else act = ACT_GETSIG;
      caller = $urandom_range(0, hi);
      target = ($urandom_range(3) == 0) ? $urandom_range(0, 4) : $urandom_range(0, hi);
      send_word(act, caller, target, $urandom, 1'($urandom), 1'($urandom), pick_sig());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1;

    send_word(ACT_ALLOC, 1, 0, 0, 0, 0, 0);
    send_word(ACT_GETSIG, 1, 2, 0, 0, 0, 0);
    send_word(ACT_SETSIG, 1, 2, 0, 0, 0, 8'd19);
    send_word(ACT_SETSIG, 1, 2, 0, 0, 0, 8'd17);
    send_word(ACT_SETSIG, 1, 2, 0, 0, 0, 8'd19);
    send_word(ACT_GETSIG, 1, 2, 0, 0, 0, 0);
    send_word(ACT_SETSIG, 1, 2, 0, 0, 0, 8'h80);
    send_word(ACT_SETSIG, 1, 2, 0, 0, 0, 8'd127);
    send_word(ACT_SETSIG, 1, 2, 0, 0, 0, 8'd0);
    send_word(ACT_SETSIG, 1, 9999, 0, 0, 0, 8'd9);
    send_word(ACT_JOIN, 1, 2, 0, 0, 1, 0);
    send_word(ACT_JOIN, 1, 2, 0, 0, 0, 0);
    send_word(ACT_JOIN, 2, 2, 0, 0, 0, 0);
    send_word(ACT_JOIN, 2, 1, 0, 0, 0, 0);
    send_word(ACT_JOIN, 5, 2, 0, 0, 0, 0);
    send_word(ACT_ALLOC, 2, 0, 0, 0, 0, 0);
    send_word(ACT_EXIT, 2, 0, 32'h8000_0000, 1, 0, 0);
    send_word(ACT_JOIN, 1, 2, 0, 0, 0, 0);
    send_word(ACT_EXIT, 2, 0, 32'h7fff_ffff, 0, 0, 0);
    send_word(ACT_UNALLOC, 1, 2, 0, 0, 0, 0);
    send_word(ACT_DETACH, 1, 1, 0, 0, 0, 0);
    send_word(ACT_DETACH, 2, 3, 0, 0, 0, 0);
    send_word(ACT_UNALLOC, 1, 0, 0, 0, 0, 0);
    send_word(ACT_UNALLOC, 1, 32767, 0, 0, 0, 0);
    send_word(ACT_BAD, 32767, 32767, 32'hffff_ffff, 1, 1, 8'hff);
    send_word(ACT_EXIT, 32767, 0, 0, 0, 0, 0);

    for (int i = 0; i < N_RAND; i++) begin
      calm = (i >= 800 && i < 1000);
      if (i == 600) hold_req <= 1;
      random_word();
    end
    calm = 0;
    in_valid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

### files.f
hw/rtl/pit_pkg.sv
hw/rtl/pit_ram.sv
hw/rtl/pit_mod.sv
hw/rtl/process_id_table.sv
tb/pit_checker.sv
tb/process_id_table_tb.sv
